// File: hw/rtl/bcomp_pkg.sv
// Shared constants, types and multiplier helpers for the barometric compensation block.
package bcomp_pkg;

    localparam int RawW      = 20;
    localparam int TempW     = 24;
    localparam int PressW    = 32;
    localparam int DenW      = 31;
    localparam int DivStep   = 2;
    localparam int DivStages = 64 / DivStep;
    localparam int AddrW     = 5;
    localparam int DataW     = 64;

    localparam logic [1:0] RegCalTemp      = 2'd0;
    localparam logic [1:0] RegCalPressLo   = 2'd1;
    localparam logic [1:0] RegCalPressHi   = 2'd2;
    localparam logic [1:0] RegCalPressNine = 2'd3;

    typedef struct packed {
        logic [TempW-1:0] temp;
        logic             invalid;
        logic             neg;
    } side_t;

    // low word of a times a small signed factor, sign-extended to 64 bits
    function automatic logic [63:0] mul_lo_part(input logic [63:0] a,
                                                 input logic signed [16:0] b);
        logic signed [49:0] p;
        p = $signed({1'b0, a[31:0]}) * b;
        return 64'(p);
    endfunction

    // high word of a times a small signed factor, low 32 bits only
    function automatic logic [31:0] mul_hi_part(input logic [63:0] a,
                                                input logic signed [16:0] b);
        logic [31:0] bx;
        logic [63:0] p;
        bx = 32'(b);
        p  = a[63:32] * bx;
        return p[31:0];
    endfunction

endpackage

// File: hw/rtl/bcomp_if.sv
// Valid/ready channel interfaces for raw samples and compensated results.
interface bcomp_in_if;
    logic                          valid;
    logic                          ready;
    logic [bcomp_pkg::RawW-1:0]    raw_temp;
    logic [bcomp_pkg::RawW-1:0]    raw_press;
    modport source (output valid, raw_temp, raw_press, input ready);
    modport sink   (input valid, raw_temp, raw_press, output ready);
endinterface

interface bcomp_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bcomp_pkg::TempW-1:0]  temp_centi;
    logic [bcomp_pkg::PressW-1:0]        press_q24_8;
    logic                                press_invalid;
    modport source (output valid, temp_centi, press_q24_8, press_invalid, input ready);
    modport sink   (input valid, temp_centi, press_q24_8, press_invalid, output ready);
endinterface

// File: hw/rtl/bcomp_div.sv
// Pipelined restoring divider, 64-bit magnitude by 31-bit magnitude, two bits a stage.
module bcomp_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [63:0]            in_num,
    input  logic [bcomp_pkg::DenW-1:0] in_den,
    input  bcomp_pkg::side_t       in_side,
    output logic                   out_valid,
    output logic [63:0]            out_quo,
    output bcomp_pkg::side_t       out_side
);
    import bcomp_pkg::*;

    logic [DivStages-1:0] v_reg;
    logic [DenW-1:0]      rem_reg  [DivStages];
    logic [DenW-1:0]      rem_next [DivStages];
    logic [63:0]          quo_reg  [DivStages];
    logic [63:0]          quo_next [DivStages];
    logic [DenW-1:0]      den_reg  [DivStages];
    side_t                side_reg [DivStages];

    always_comb
    begin
        logic [DenW-1:0] r;
        logic [63:0]     n;
        logic [DenW:0]   t;
        logic [DenW-1:0] dv;
        for (int s = 0; s < DivStages; s++)
        begin
            if (s == 0)
            begin
                r  = '0;
                n  = in_num;
                dv = in_den;
            end
            else
            begin
                r  = rem_reg[s-1];
                n  = quo_reg[s-1];
                dv = den_reg[s-1];
            end
            for (int j = 0; j < DivStep; j++)
            begin
                t = {r, n[63]};
                n = {n[62:0], 1'b0};
                if (t >= {1'b0, dv})
                begin
                    t    = t - {1'b0, dv};
                    n[0] = 1'b1;
                end
                r = t[DenW-1:0];
            end
            rem_next[s] = r;
            quo_next[s] = n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[DivStages-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DivStages; s++)
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
                den_reg[s] <= (s == 0) ? in_den : den_reg[s-1];
                side_reg[s] <= (s == 0) ? in_side : side_reg[s-1];
            end
        end
    end

    assign out_valid = v_reg[DivStages-1];
    assign out_quo   = quo_reg[DivStages-1];
    assign out_side  = side_reg[DivStages-1];

endmodule

// File: hw/rtl/baro_temp_pressure_compensation_top.sv
// Top level of the barometric temperature and pressure compensation pipeline.
// Takes one raw temperature/pressure pair per cycle and returns one result per pair, in order,
// through 12 stages of temperature and pressure prescaling, a 32-stage divider retiring
// two quotient bits a stage, 6 stages of pressure correction and a 2-entry output queue.
// Sustained rate is one item per cycle; the whole pipeline holds while the output queue
// is full. Calibration words sit in four APB registers at byte addresses 0, 8, 16 and 24
// and must only be written while the block is idle.
module baro_temp_pressure_compensation_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bcomp_pkg::AddrW-1:0] paddr,
    input  logic [bcomp_pkg::DataW-1:0] pwdata,
    output logic [bcomp_pkg::DataW-1:0] prdata,
    output logic                        pready,
    bcomp_in_if.sink                    sample,
    bcomp_out_if.source                 result
);
    import bcomp_pkg::*;

    logic [47:0] cal_temp_reg;
    logic [63:0] cal_press_lo_reg;
    logic [63:0] cal_press_hi_reg;
    logic [15:0] cal_press_nine_reg;

    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_reg       <= '0;
            cal_press_lo_reg   <= '0;
            cal_press_hi_reg   <= '0;
            cal_press_nine_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                RegCalTemp:      cal_temp_reg       <= pwdata[47:0];
                RegCalPressLo:   cal_press_lo_reg   <= pwdata;
                RegCalPressHi:   cal_press_hi_reg   <= pwdata;
                RegCalPressNine: cal_press_nine_reg <= pwdata[15:0];
                default:         cal_temp_reg       <= cal_temp_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            RegCalTemp:      prdata = {16'h0, cal_temp_reg};
            RegCalPressLo:   prdata = cal_press_lo_reg;
            RegCalPressHi:   prdata = cal_press_hi_reg;
            RegCalPressNine: prdata = {48'h0, cal_press_nine_reg};
            default:         prdata = '0;
        endcase
    end

    logic [15:0]        t1;
    logic signed [15:0] t2, t3;
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = cal_temp_reg[15:0];
    assign t2 = $signed(cal_temp_reg[31:16]);
    assign t3 = $signed(cal_temp_reg[47:32]);
    assign p1 = cal_press_lo_reg[15:0];
    assign p2 = $signed(cal_press_lo_reg[31:16]);
    assign p3 = $signed(cal_press_lo_reg[47:32]);
    assign p4 = $signed(cal_press_lo_reg[63:48]);
    assign p5 = $signed(cal_press_hi_reg[15:0]);
    assign p6 = $signed(cal_press_hi_reg[31:16]);
    assign p7 = $signed(cal_press_hi_reg[47:32]);
    assign p8 = $signed(cal_press_hi_reg[63:48]);
    assign p9 = $signed(cal_press_nine_reg);

    logic       en;
    logic [1:0] cnt_reg;

    assign en           = (cnt_reg != 2'd2);
    assign sample.ready = en;

    logic        div_valid;
    logic [63:0] div_quo;
    side_t       div_side;

    logic [11:0] pv_reg;
    logic [5:0]  qv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
            qv_reg <= '0;
        end
        else if (en)
        begin
            pv_reg <= {pv_reg[10:0], sample.valid};
            qv_reg <= {qv_reg[4:0], div_valid};
        end
    end

    // front stages
    logic [31:0]        a1_reg, d1_reg;
    logic [20:0]        nb1_reg, nb2_reg, nb3_reg, nb4_reg, nb5_reg, nb6_reg, nb7_reg, nb8_reg;
    logic [31:0]        m1_2_reg, dd_2_reg;
    logic [31:0]        v1_3_reg, m2_3_reg;
    logic [31:0]        tf_4_reg;
    logic [TempW-1:0]   temp5_reg, temp6_reg, temp7_reg, temp8_reg, temp9_reg;
    logic [TempW-1:0]   temp10_reg, temp11_reg;
    logic signed [32:0] x1_5_reg;
    logic [63:0]        sq_6_reg;
    logic signed [48:0] xp5_6_reg, xp2_6_reg;
    logic [63:0]        a6_7_reg, a3_7_reg, x2b_7_reg, x1p_7_reg;
    logic [31:0]        b6_7_reg, b3_7_reg;
    logic [63:0]        x2_8_reg, sq3_8_reg, x1p_8_reg;
    logic [63:0]        x1c_9_reg, num0_9_reg;
    logic [63:0]        ap_10_reg, an_10_reg;
    logic [31:0]        bp_10_reg, bn_10_reg;
    logic [63:0]        prod_11_reg, num_11_reg;
    logic [63:0]        ma_12_reg;
    logic [DenW-1:0]    mb_12_reg;
    side_t              side_12_reg;

    logic [31:0]        a1_next, d1_next, m1_next, dd_next, m2_next, tf_next, tc_next;
    logic [63:0]        m1_full, dd_full, m2_full, sq_full;
    logic signed [65:0] sq_wide;
    logic [63:0]        x2_next, x1c_next, num0_next, prod_next, num_next;
    logic [DenW-1:0]    x1d, mb_next;
    logic               inv_next;

    assign a1_next   = 32'(sample.raw_temp >> 3) - 32'({t1, 1'b0});
    assign d1_next   = 32'(sample.raw_temp >> 4) - 32'(t1);
    assign m1_full   = a1_reg * 32'(t2);
    assign dd_full   = d1_reg * d1_reg;
    assign m1_next   = m1_full[31:0];
    assign dd_next   = dd_full[31:0];
    assign m2_full   = 32'($signed(dd_2_reg) >>> 12) * 32'(t3);
    assign m2_next   = m2_full[31:0];
    assign tf_next   = v1_3_reg + 32'($signed(m2_3_reg) >>> 14);
    assign tc_next   = (tf_4_reg << 2) + tf_4_reg + 32'd128;
    assign sq_wide   = x1_5_reg * x1_5_reg;
    assign sq_full   = sq_wide[63:0];
    assign x2_next   = a6_7_reg + {b6_7_reg, 32'h0} + x2b_7_reg + (64'($signed(p4)) << 35);
    assign x1c_next  = 64'($signed(sq3_8_reg) >>> 8) + x1p_8_reg + (64'd1 << 47);
    assign num0_next = {12'h0, nb8_reg, 31'h0} - x2_8_reg;
    assign prod_next = ap_10_reg + {bp_10_reg, 32'h0};
    assign num_next  = an_10_reg + {bn_10_reg, 32'h0};
    assign x1d       = prod_11_reg[63:33];
    assign inv_next  = (x1d == '0);
    assign mb_next   = inv_next ? DenW'(1) : (x1d[DenW-1] ? (~x1d + DenW'(1)) : x1d);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg      <= a1_next;
            d1_reg      <= d1_next;
            nb1_reg     <= 21'd1048576 - 21'(sample.raw_press);
            m1_2_reg    <= m1_next;
            dd_2_reg    <= dd_next;
            nb2_reg     <= nb1_reg;
            v1_3_reg    <= 32'($signed(m1_2_reg) >>> 11);
            m2_3_reg    <= m2_next;
            nb3_reg     <= nb2_reg;
            tf_4_reg    <= tf_next;
            nb4_reg     <= nb3_reg;
            temp5_reg   <= TempW'($signed(tc_next) >>> 8);
            x1_5_reg    <= $signed({tf_4_reg[31], tf_4_reg}) - 33'sd128000;
            nb5_reg     <= nb4_reg;
            sq_6_reg    <= sq_full;
            xp5_6_reg   <= x1_5_reg * p5;
            xp2_6_reg   <= x1_5_reg * p2;
            temp6_reg   <= temp5_reg;
            nb6_reg     <= nb5_reg;
            a6_7_reg    <= mul_lo_part(sq_6_reg, 17'(p6));
            b6_7_reg    <= mul_hi_part(sq_6_reg, 17'(p6));
            a3_7_reg    <= mul_lo_part(sq_6_reg, 17'(p3));
            b3_7_reg    <= mul_hi_part(sq_6_reg, 17'(p3));
            x2b_7_reg   <= 64'(xp5_6_reg) << 17;
            x1p_7_reg   <= 64'(xp2_6_reg) << 12;
            temp7_reg   <= temp6_reg;
            nb7_reg     <= nb6_reg;
            x2_8_reg    <= x2_next;
            sq3_8_reg   <= a3_7_reg + {b3_7_reg, 32'h0};
            x1p_8_reg   <= x1p_7_reg;
            temp8_reg   <= temp7_reg;
            nb8_reg     <= nb7_reg;
            x1c_9_reg   <= x1c_next;
            num0_9_reg  <= num0_next;
            temp9_reg   <= temp8_reg;
            ap_10_reg   <= mul_lo_part(x1c_9_reg, $signed({1'b0, p1}));
            bp_10_reg   <= mul_hi_part(x1c_9_reg, $signed({1'b0, p1}));
            an_10_reg   <= mul_lo_part(num0_9_reg, 17'sd3125);
            bn_10_reg   <= mul_hi_part(num0_9_reg, 17'sd3125);
            temp10_reg  <= temp9_reg;
            prod_11_reg <= prod_next;
            num_11_reg  <= num_next;
            temp11_reg  <= temp10_reg;
            ma_12_reg   <= num_11_reg[63] ? (~num_11_reg + 64'd1) : num_11_reg;
            mb_12_reg   <= mb_next;
            side_12_reg <= '{temp: temp11_reg, invalid: inv_next,
                             neg: num_11_reg[63] ^ x1d[DenW-1]};
        end
    end

    bcomp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pv_reg[11]),
        .in_num    (ma_12_reg),
        .in_den    (mb_12_reg),
        .in_side   (side_12_reg),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    // back stages
    logic [63:0] q_a_reg, q_b_reg, q_c_reg, q_d_reg, q_e_reg;
    side_t       s_a_reg, s_b_reg, s_c_reg, s_d_reg, s_e_reg, s_f_reg;
    logic [63:0] pp0_b_reg, a8_b_reg;
    logic [31:0] pc_b_reg, b8_b_reg;
    logic [63:0] sqp_c_reg, y2_c_reg, y2_d_reg, y2_e_reg;
    logic [63:0] a9_d_reg, y1_e_reg, f_reg;
    logic [31:0] b9_d_reg;

    logic [63:0] ph, pp0_next, pc_full, fsum, f_next;

    assign ph       = 64'($signed(q_a_reg) >>> 13);
    assign pp0_next = ph[31:0] * ph[31:0];
    assign pc_full  = ph[31:0] * ph[63:32];
    assign fsum     = q_e_reg + y1_e_reg + y2_e_reg;
    assign f_next   = 64'($signed(fsum) >>> 8) + (64'($signed(p7)) << 4);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_a_reg   <= div_side.neg ? (~div_quo + 64'd1) : div_quo;
            s_a_reg   <= div_side;
            pp0_b_reg <= pp0_next;
            pc_b_reg  <= pc_full[31:0];
            a8_b_reg  <= mul_lo_part(q_a_reg, 17'(p8));
            b8_b_reg  <= mul_hi_part(q_a_reg, 17'(p8));
            q_b_reg   <= q_a_reg;
            s_b_reg   <= s_a_reg;
            sqp_c_reg <= pp0_b_reg + {pc_b_reg[30:0], 1'b0, 32'h0};
            y2_c_reg  <= 64'($signed(a8_b_reg + {b8_b_reg, 32'h0}) >>> 19);
            q_c_reg   <= q_b_reg;
            s_c_reg   <= s_b_reg;
            a9_d_reg  <= mul_lo_part(sqp_c_reg, 17'(p9));
            b9_d_reg  <= mul_hi_part(sqp_c_reg, 17'(p9));
            y2_d_reg  <= y2_c_reg;
            q_d_reg   <= q_c_reg;
            s_d_reg   <= s_c_reg;
            y1_e_reg  <= 64'($signed(a9_d_reg + {b9_d_reg, 32'h0}) >>> 25);
            y2_e_reg  <= y2_d_reg;
            q_e_reg   <= q_d_reg;
            s_e_reg   <= s_d_reg;
            f_reg     <= f_next;
            s_f_reg   <= s_e_reg;
        end
    end

    // output queue
    logic [PressW-1:0] press_sat;
    logic              push, pop;
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [TempW-1:0]  oq_temp_reg  [2];
    logic [PressW-1:0] oq_press_reg [2];
    logic              oq_inv_reg   [2];

    always_comb
    begin
        if (s_f_reg.invalid || f_reg[63])
        begin
            press_sat = '0;
        end
        else if (f_reg[62:32] != '0)
        begin
            press_sat = '1;
        end
        else
        begin
            press_sat = f_reg[31:0];
        end
    end

    assign push = en & qv_reg[5];
    assign pop  = result.valid & result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_reg + 2'(push) - 2'(pop);
            wr_ptr_reg <= wr_ptr_reg ^ push;
            rd_ptr_reg <= rd_ptr_reg ^ pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            oq_temp_reg[wr_ptr_reg]  <= s_f_reg.temp;
            oq_press_reg[wr_ptr_reg] <= press_sat;
            oq_inv_reg[wr_ptr_reg]   <= s_f_reg.invalid;
        end
    end

    assign result.valid         = (cnt_reg != 2'd0);
    assign result.temp_centi    = $signed(oq_temp_reg[rd_ptr_reg]);
    assign result.press_q24_8   = oq_press_reg[rd_ptr_reg];
    assign result.press_invalid = oq_inv_reg[rd_ptr_reg];

endmodule

// File: dv/baro_temp_pressure_compensation_top_tb.sv
// Self-checking testbench: random and directed raw samples against a compensation predictor.
module baro_temp_pressure_compensation_top_tb;
    import bcomp_pkg::*;

    typedef struct packed {
        logic [RawW-1:0] raw_temp;
        logic [RawW-1:0] raw_press;
    } sample_t;

    typedef struct packed {
        logic [TempW-1:0]  temp_centi;
        logic [PressW-1:0] press_q24_8;
        logic              press_invalid;
    } reading_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [AddrW-1:0]   paddr;
    logic [DataW-1:0]   pwdata;
    logic [DataW-1:0]   prdata;
    logic               pready;

    bcomp_in_if  smp ();
    bcomp_out_if res ();

    baro_temp_pressure_compensation_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (smp.sink),
        .result  (res.source)
    );

    logic [47:0] cal_t;
    logic [63:0] cal_plo;
    logic [63:0] cal_phi;
    logic [15:0] cal_p9;

    sample_t  raw_queue[$];
    reading_t pending_readings[$];
    int       mismatches;
    int       send_gap;
    int       recv_gap;
    bit       quiet;

    function automatic logic [63:0] sx16(input logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

    function automatic reading_t compensate(input sample_t s);
        logic [31:0] adc_t, t1, t2, t3, a, v1, d, v2, tfine, m;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] tf, x1, x2, pp, num, q, ma, mb, ph, y1, y2;
        reading_t    r;
        adc_t = {12'b0, s.raw_temp};
        t1 = {16'b0, cal_t[15:0]};
        t2 = {{16{cal_t[31]}}, cal_t[31:16]};
        t3 = {{16{cal_t[47]}}, cal_t[47:32]};
        p1 = {48'b0, cal_plo[15:0]};
        p2 = sx16(cal_plo[31:16]);
        p3 = sx16(cal_plo[47:32]);
        p4 = sx16(cal_plo[63:48]);
        p5 = sx16(cal_phi[15:0]);
        p6 = sx16(cal_phi[31:16]);
        p7 = sx16(cal_phi[47:32]);
        p8 = sx16(cal_phi[63:48]);
        p9 = sx16(cal_p9);

        a  = (adc_t >> 3) - (t1 << 1);
        m  = a * t2;
        v1 = $signed(m) >>> 11;
        d  = (adc_t >> 4) - t1;
        m  = d * d;
        m  = $signed(m) >>> 12;
        m  = m * t3;
        v2 = $signed(m) >>> 14;
        tfine = v1 + v2;
        m  = tfine * 32'd5 + 32'd128;
        m  = $signed(m) >>> 8;
        r.temp_centi = m[TempW-1:0];

        tf = {{32{tfine[31]}}, tfine};
        x1 = tf - 64'd128000;
        x2 = x1 * x1 * p6 + ((x1 * p5) << 17) + (p4 << 35);
        q  = x1 * x1 * p3;
        q  = $signed(q) >>> 8;
        x1 = q + ((x1 * p2) << 12);
        x1 = 64'h0000_8000_0000_0000 + x1;
        q  = x1 * p1;
        x1 = $signed(q) >>> 33;

        r.press_q24_8   = '0;
        r.press_invalid = 1'b0;
        if (x1 == 64'd0)
            r.press_invalid = 1'b1;
        else
        begin
            pp  = 64'd1048576 - {44'b0, s.raw_press};
            num = ((pp << 31) - x2) * 64'd3125;
            ma  = num[63] ? -num : num;
            mb  = x1[63] ? -x1 : x1;
            q   = ma / mb;
            pp  = (num[63] ^ x1[63]) ? -q : q;
            ph  = $signed(pp) >>> 13;
            q   = p9 * ph * ph;
            y1  = $signed(q) >>> 25;
            q   = p8 * pp;
            y2  = $signed(q) >>> 19;
            q   = pp + y1 + y2;
            q   = $signed(q) >>> 8;
            pp  = q + (p7 << 4);
            if (pp[63])
                r.press_q24_8 = '0;
            else if (pp[63:32] != 32'd0)
                r.press_q24_8 = '1;
            else
                r.press_q24_8 = pp[31:0];
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatches++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp.valid     <= 1'b0;
            smp.raw_temp  <= '0;
            smp.raw_press <= '0;
            send_gap      <= 0;
        end
        else
        begin
            if (smp.valid && smp.ready)
                pending_readings.push_back(compensate({smp.raw_temp, smp.raw_press}));
            if (!smp.valid || smp.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap  <= send_gap - 1;
                    smp.valid <= 1'b0;
                end
                else if (raw_queue.size() > 0 && !quiet && $urandom_range(0, 5) == 0)
                begin
                    send_gap  <= $urandom_range(0, 2);
                    smp.valid <= 1'b0;
                end
                else if (raw_queue.size() > 0)
                begin
                    smp.valid     <= 1'b1;
                    smp.raw_temp  <= raw_queue[0].raw_temp;
                    smp.raw_press <= raw_queue[0].raw_press;
                    void'(raw_queue.pop_front());
                end
                else
                    smp.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (pending_readings.size() == 0)
                    report("unexpected result", 64'(res.press_q24_8), '0);
                else
                begin
                    want = pending_readings.pop_front();
                    if (res.temp_centi !== want.temp_centi)
                        report("temp_centi", 64'(res.temp_centi), 64'(want.temp_centi));
                    if (res.press_q24_8 !== want.press_q24_8)
                        report("press_q24_8", 64'(res.press_q24_8), 64'(want.press_q24_8));
                    if (res.press_invalid !== want.press_invalid)
                        report("press_invalid", 64'(res.press_invalid),
                               64'(want.press_invalid));
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                res.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                recv_gap  <= $urandom_range(0, 2);
                res.ready <= 1'b0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'({idx, 3'b000});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            RegCalTemp:      cal_t   = value[47:0];
            RegCalPressLo:   cal_plo = value;
            RegCalPressHi:   cal_phi = value;
            RegCalPressNine: cal_p9  = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_cal(input logic [63:0] ct, input logic [63:0] lo, input logic [63:0] hi,
                           input logic [63:0] nine);
        write_reg(RegCalTemp, ct);
        write_reg(RegCalPressLo, lo);
        write_reg(RegCalPressHi, hi);
        write_reg(RegCalPressNine, nine);
    endtask

    task automatic drain();
        while (raw_queue.size() > 0 || smp.valid || pending_readings.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic add_random(input int n);
        sample_t s;
        repeat (n)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                s.raw_temp  = RawW'($urandom);
                s.raw_press = RawW'($urandom);
            end
            else
            begin
                s.raw_temp  = RawW'($urandom_range(415000, 560000));
                s.raw_press = RawW'($urandom_range(250000, 420000));
            end
            raw_queue.push_back(s);
        end
    endtask

    initial
    begin
        logic [63:0] typ_t, typ_lo, typ_hi, typ_nine;
        typ_t    = 64'({16'hFC18, 16'd26435, 16'd27504});
        typ_lo   = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
        typ_hi   = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
        typ_nine = 64'd6000;
        mismatches = 0;
        quiet   = 1'b0;
        cal_t   = '0;
        cal_plo = '0;
        cal_phi = '0;
        cal_p9  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // zero calibration: divisor is zero
        raw_queue.push_back('{20'h00000, 20'h00000});
        raw_queue.push_back('{20'hFFFFF, 20'hFFFFF});
        raw_queue.push_back('{20'h80000, 20'h7FFFF});
        drain();

        set_cal(typ_t, typ_lo, typ_hi, typ_nine);
        raw_queue.push_back('{20'h00000, 20'h00000});
        raw_queue.push_back('{20'hFFFFF, 20'hFFFFF});
        raw_queue.push_back('{20'h00000, 20'hFFFFF});
        raw_queue.push_back('{20'hFFFFF, 20'h00000});
        raw_queue.push_back('{20'd519888, 20'd415148});
        raw_queue.push_back('{20'hAAAAA, 20'h55555});
        raw_queue.push_back('{20'h55555, 20'hAAAAA});
        add_random(150);
        drain();

        // all ones and sign-bit extremes
        set_cal('1, '1, '1, '1);
        raw_queue.push_back('{20'h00000, 20'h00000});
        raw_queue.push_back('{20'hFFFFF, 20'hFFFFF});
        add_random(30);
        drain();
        set_cal(64'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000, 64'h8000);
        raw_queue.push_back('{20'h00000, 20'hFFFFF});
        raw_queue.push_back('{20'hFFFFF, 20'h00000});
        add_random(30);
        drain();
        set_cal(64'h7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF);
        add_random(30);
        drain();

        repeat (6)
        begin
            set_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    64'($urandom));
            add_random(20);
            drain();
        end

        set_cal(typ_t, typ_lo, typ_hi, typ_nine);
        add_random(100);
        quiet = 1'b1;
        add_random(40);
        drain();

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
